@@ design/awb_pkg.sv @@
// Package for the affine warp bilinear sampler.
// Holds the sequencer state type, register indexes, command codes, fixed widths and the clamp margin.
// Used by affine_warp_bilinear; no dependencies.
`default_nettype none
package awb_pkg;

   // Sequencer states of the sampling engine.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_WGT,
      ST_ADDR,
      ST_READ,
      ST_DONE
   } awb_state_type;

   // Register indexes on the CSR port.
   localparam logic [2:0] REG_COEF_XX = 3'd0;
   localparam logic [2:0] REG_COEF_XY = 3'd1;
   localparam logic [2:0] REG_COEF_XO = 3'd2;
   localparam logic [2:0] REG_COEF_YX = 3'd3;
   localparam logic [2:0] REG_COEF_YY = 3'd4;
   localparam logic [2:0] REG_COEF_YO = 3'd5;
   localparam logic [2:0] REG_SRC_W   = 3'd6;
   localparam logic [2:0] REG_SRC_H   = 3'd7;

   // Command codes carried in req_tuser.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Field widths.
   localparam int LOAD_ADDR_W = 18;
   localparam int SAMPLE_W    = 16;
   localparam int COORD_W     = 8;
   localparam int SIZE_W      = 9;
   localparam int REQ_DATA_W  = 56;

   // 1.05 in Q16.16, rounded up.
   localparam int MARGIN_Q16 = 68813;

endpackage
`default_nettype wire

@@ design/affine_warp_bilinear.sv @@
// Affine warp sampler with bilinear interpolation: the source store, the coordinate
// mapper and the blending sequencer. Depends on awb_pkg and awb_ram.
//
// A load word (tuser 0) writes one sample into the source store; loads are taken
// only while idle. A sample word (tuser 1) maps (out_x, out_y) through the Q16.16
// matrix, clamps to [0, size-1.05] and returns CHANNELS result words, one per
// channel, tlast on the last. The store has a single port, so each channel costs
// four reads in ST_READ plus a blend step in ST_DONE: after a sample word is taken
// the block maps it through ST_MUL, ST_SUM, ST_WGT and ST_ADDR, then blends each
// channel, and takes the next word only once back in ST_IDLE, so no new sample word
// is taken before the last one is done; rsp_tready stalls hold it in ST_DONE. The
// store holds no reset value; sample only pixels that were loaded.
`default_nettype none
module affine_warp_bilinear #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int CHANNELS       = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [17:0] load_addr, [33:18] load_value, [41:34] out_x, [49:42] out_y, rest zero
   input  wire logic [55:0] req_tdata,
   // [0] cmd
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] pixel_value
   output logic      [15:0] rsp_tdata,
   // [1:0] channel_index
   output logic      [1:0]  rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import awb_pkg::*;

   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT * CHANNELS;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = (AW > LOAD_ADDR_W) ? AW : LOAD_ADDR_W;
   localparam int XW    = $clog2(MAX_SRC_WIDTH);
   localparam int YW    = $clog2(MAX_SRC_HEIGHT);
   localparam int SWW   = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SHW   = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW    = 44;
   localparam int ACW   = 49;

   // Configuration registers.
   logic [31:0]       coef_xx_ff, coef_xy_ff, coef_xo_ff;
   logic [31:0]       coef_yx_ff, coef_yy_ff, coef_yo_ff;
   logic [SIZE_W-1:0] src_w_ff, src_h_ff;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xx_ff <= 32'd65536;
         coef_xy_ff <= '0;
         coef_xo_ff <= '0;
         coef_yx_ff <= '0;
         coef_yy_ff <= 32'd65536;
         coef_yo_ff <= '0;
         src_w_ff   <= 9'd256;
         src_h_ff   <= 9'd256;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_COEF_XX: coef_xx_ff <= csr_pwdata;
            REG_COEF_XY: coef_xy_ff <= csr_pwdata;
            REG_COEF_XO: coef_xo_ff <= csr_pwdata;
            REG_COEF_YX: coef_yx_ff <= csr_pwdata;
            REG_COEF_YY: coef_yy_ff <= csr_pwdata;
            REG_COEF_YO: coef_yo_ff <= csr_pwdata;
            REG_SRC_W:   src_w_ff   <= csr_pwdata[SIZE_W-1:0];
            REG_SRC_H:   src_h_ff   <= csr_pwdata[SIZE_W-1:0];
            default:     ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_paddr[4:2])
         REG_COEF_XX: csr_prdata = coef_xx_ff;
         REG_COEF_XY: csr_prdata = coef_xy_ff;
         REG_COEF_XO: csr_prdata = coef_xo_ff;
         REG_COEF_YX: csr_prdata = coef_yx_ff;
         REG_COEF_YY: csr_prdata = coef_yy_ff;
         REG_COEF_YO: csr_prdata = coef_yo_ff;
         REG_SRC_W:   csr_prdata = 32'(src_w_ff);
         REG_SRC_H:   csr_prdata = 32'(src_h_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // Effective image size, held to [2, maximum].
   logic [SWW-1:0] w_lim;
   logic [SHW-1:0] h_lim;

   always_comb begin
      if (32'(src_w_ff) < 32'd2) begin
         w_lim = SWW'(2);
      end else if (32'(src_w_ff) > 32'(MAX_SRC_WIDTH)) begin
         w_lim = SWW'(MAX_SRC_WIDTH);
      end else begin
         w_lim = SWW'(src_w_ff);
      end
      if (32'(src_h_ff) < 32'd2) begin
         h_lim = SHW'(2);
      end else if (32'(src_h_ff) > 32'(MAX_SRC_HEIGHT)) begin
         h_lim = SHW'(MAX_SRC_HEIGHT);
      end else begin
         h_lim = SHW'(src_h_ff);
      end
   end

   // Input word fields.
   logic [LOAD_ADDR_W-1:0] load_addr;
   logic [SAMPLE_W-1:0]    load_value;
   logic [COORD_W-1:0]     out_x, out_y;
   logic [LW-1:0]          load_addr_ext;
   logic                   load_in_range;

   assign load_addr     = req_tdata[17:0];
   assign load_value    = req_tdata[33:18];
   assign out_x         = req_tdata[41:34];
   assign out_y         = req_tdata[49:42];
   assign load_addr_ext = LW'(load_addr);
   assign load_in_range = 32'(load_addr) < 32'(DEPTH);

   // Datapath registers.
   awb_state_type             state_ff, state_in;
   logic [COORD_W-1:0]        x_ff, x_in, y_ff, y_in;
   logic signed [40:0]        mxx_ff, mxy_ff, myx_ff, myy_ff;
   logic [XW+15:0]            pxc_ff;
   logic [YW+15:0]            pyc_ff;
   logic [32:0]               wgt_ff [4];
   logic [AW-1:0]             row_ff, base_ff, stride_ff;
   logic [1:0]                k_ff, k_in;
   logic [CW-1:0]             ch_ff, ch_in;
   logic [ACW-1:0]            acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]               pix_ff, pix_in;
   logic [1:0]                chan_ff, chan_in;
   logic                      last_ff, last_in;

   // Map stage: sum of products and clamp to the valid source window.
   logic signed [PW-1:0] px_raw, py_raw, hi_x, hi_y, px_cl, py_cl;

   assign px_raw = PW'(mxx_ff) + PW'(mxy_ff) + PW'($signed(coef_xo_ff));
   assign py_raw = PW'(myx_ff) + PW'(myy_ff) + PW'($signed(coef_yo_ff));
   assign hi_x   = $signed(PW'({w_lim, 16'h0})) - $signed(PW'(MARGIN_Q16));
   assign hi_y   = $signed(PW'({h_lim, 16'h0})) - $signed(PW'(MARGIN_Q16));

   always_comb begin
      px_cl = px_raw;
      if (px_raw > hi_x) begin
         px_cl = hi_x;
      end else if (px_raw < 0) begin
         px_cl = '0;
      end
      py_cl = py_raw;
      if (py_raw > hi_y) begin
         py_cl = hi_y;
      end else if (py_raw < 0) begin
         py_cl = '0;
      end
   end

   // Corner weights from the fractions.
   logic [16:0] gx, gy, fx, fy;
   logic [XW-1:0] ix;
   logic [YW-1:0] iy;

   assign fx = {1'b0, pxc_ff[15:0]};
   assign fy = {1'b0, pyc_ff[15:0]};
   assign gx = 17'h10000 - fx;
   assign gy = 17'h10000 - fy;
   assign ix = pxc_ff[XW+15:16];
   assign iy = pyc_ff[YW+15:16];

   // Store port: loads in idle, neighbor reads while blending.
   logic [AW-1:0]       ram_addr, rd_off;
   logic                ram_en, ram_we;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic                load_acc;

   assign load_acc = req_tvalid && req_tready && (req_tuser == CMD_LOAD);

   always_comb begin
      case (k_ff)
         2'd0:    rd_off = '0;
         2'd1:    rd_off = AW'(CHANNELS);
         2'd2:    rd_off = stride_ff;
         default: rd_off = stride_ff + AW'(CHANNELS);
      endcase
   end

   always_comb begin
      ram_we = load_acc && load_in_range;
      ram_en = ram_we || (state_ff == ST_READ);
      if (state_ff == ST_READ) begin
         ram_addr = base_ff + AW'(ch_ff) + rd_off;
      end else begin
         ram_addr = load_addr_ext[AW-1:0];
      end
   end

   awb_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(load_value),
      .rdata(ram_rdata)
   );

   // Shared blend multiplier: weight of the corner read most recently times its sample.
   logic [32:0]    wsel;
   logic [ACW-1:0] prod, fin;
   logic [ACW-1:0] rnd;
   logic [16:0]    vround;

   always_comb begin
      if (state_ff == ST_DONE) begin
         wsel = wgt_ff[3];
      end else begin
         wsel = wgt_ff[k_ff - 2'd1];
      end
   end

   assign prod   = ACW'(wsel) * ACW'(ram_rdata);
   assign fin    = acc_ff + prod;
   assign rnd    = fin + ACW'(64'h8000_0000);
   assign vround = rnd[ACW-1:32];

   // Sequencer: next state and control.
   logic out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      ch_in        = ch_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pix_in       = pix_ff;
      chan_in      = chan_ff;
      last_in      = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tuser == CMD_SAMPLE) begin
               x_in     = out_x;
               y_in     = out_y;
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_WGT;
         ST_WGT:  state_in = ST_ADDR;
         ST_ADDR: begin
            k_in     = '0;
            ch_in    = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            if (k_ff == 2'd0) begin
               acc_in = '0;
            end else begin
               acc_in = fin;
            end
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pix_in       = vround[16] ? 16'hFFFF : vround[15:0];
               chan_in      = 2'(ch_ff);
               last_in      = (32'(ch_ff) == CHANNELS - 1);
               k_in         = '0;
               if (32'(ch_ff) == CHANNELS - 1) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in    = ch_ff + CW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         ch_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         ch_ff        <= ch_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      pix_ff  <= pix_in;
      chan_ff <= chan_in;
      last_ff <= last_in;
      mxx_ff  <= $signed({1'b0, x_ff}) * $signed(coef_xx_ff);
      mxy_ff  <= $signed({1'b0, y_ff}) * $signed(coef_xy_ff);
      myx_ff  <= $signed({1'b0, x_ff}) * $signed(coef_yx_ff);
      myy_ff  <= $signed({1'b0, y_ff}) * $signed(coef_yy_ff);
      pxc_ff  <= px_cl[XW+15:0];
      pyc_ff  <= py_cl[YW+15:0];
      wgt_ff[0] <= 33'(34'(gx) * 34'(gy));
      wgt_ff[1] <= 33'(34'(fx) * 34'(gy));
      wgt_ff[2] <= 33'(34'(gx) * 34'(fy));
      wgt_ff[3] <= 33'(34'(fx) * 34'(fy));
      row_ff    <= AW'(AW'(iy) * AW'(w_lim));
      base_ff   <= AW'((row_ff + AW'(ix)) * AW'(CHANNELS));
      stride_ff <= AW'(AW'(w_lim) * AW'(CHANNELS));
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pix_ff;
   assign rsp_tuser  = chan_ff;
   assign rsp_tlast  = last_ff;

`ifndef SYNTHESIS
   // The channel counter never passes the channel count.
   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      32'(ch_ff) < CHANNELS)
      else $error("channel counter out of range");

   // The last mark comes only with the final channel index.
   a_last_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == 2'(CHANNELS - 1))
      else $error("last mark on wrong channel");

   // The accumulator starts each channel from zero.
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ && k_ff == 2'd0 |=> acc_ff == '0)
      else $error("accumulator not cleared");

   // The clamped corner leaves room for its right and lower neighbors.
   a_corner_in: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WGT |-> 32'(ix) + 1 < 32'(w_lim) && 32'(iy) + 1 < 32'(h_lim))
      else $error("corner outside source image");
`endif

endmodule
`default_nettype wire

@@ design/awb_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module awb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write or read one word per cycle; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule
`default_nettype wire
